FILE: sv/vlpd_pkg.sv
`default_nettype none
package vlpd_pkg;

  localparam int MAX_PREFIX_BYTES_DEFAULT = 5;
  localparam int QUEUE_DEPTH = 2;
  localparam int LENGTH_W = 32;
  localparam int GROUP_BITS = 7;

  typedef enum logic [1:0] {
    STATUS_OK          = 2'd0,
    STATUS_BAD_LENGTH  = 2'd1,
    STATUS_LONG_PREFIX = 2'd2
  } status_t;

  typedef struct packed {
    logic [7:0] payload_byte;
    logic       frame_end;
    status_t    status;
  } beat_t;

endpackage
`default_nettype wire

FILE: sv/vlpd_front.sv
`default_nettype none
module vlpd_front #(
  parameter int MAX_PREFIX_BYTES = vlpd_pkg::MAX_PREFIX_BYTES_DEFAULT
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          rx_valid,
  output logic               rx_ready,
  input  wire logic [7:0]    rx_byte,
  input  wire logic          queue_full,
  output logic               push,
  output vlpd_pkg::beat_t    push_beat
);
  import vlpd_pkg::*;

  localparam int CNT_W = $clog2(MAX_PREFIX_BYTES + 1);

  logic                in_payload;
  logic                in_payload_next;
  logic [LENGTH_W-1:0] prefix_value;
  logic [LENGTH_W-1:0] prefix_value_next;
  logic [CNT_W-1:0]    prefix_bytes_seen;
  logic [CNT_W-1:0]    prefix_bytes_seen_next;
  logic [LENGTH_W-2:0] bytes_remaining;
  logic [LENGTH_W-2:0] bytes_remaining_next;

  logic                accept;
  logic [LENGTH_W-1:0] merged;
  logic [CNT_W-1:0]    seen_inc;
  logic [LENGTH_W-2:0] remaining_dec;

  assign rx_ready = !queue_full;
  assign accept   = rx_valid && rx_ready;
  assign seen_inc = prefix_bytes_seen + CNT_W'(1);
  assign remaining_dec = bytes_remaining - (LENGTH_W-1)'(1);

  // place the 7-bit group at the slot picked by the prefix byte count
  always_comb begin
    merged = prefix_value;
    for (int i = 0; i < MAX_PREFIX_BYTES; i++) begin
      if (GROUP_BITS * i < LENGTH_W && prefix_bytes_seen == CNT_W'(i)) begin
        merged = prefix_value | (LENGTH_W'(rx_byte[GROUP_BITS-1:0]) << (GROUP_BITS * i));
      end
    end
  end

  always_comb begin
    in_payload_next        = in_payload;
    prefix_value_next      = prefix_value;
    prefix_bytes_seen_next = prefix_bytes_seen;
    bytes_remaining_next   = bytes_remaining;
    push                   = 1'b0;
    push_beat.payload_byte = 8'd0;
    push_beat.frame_end    = 1'b0;
    push_beat.status       = STATUS_OK;
    if (accept) begin
      if (in_payload) begin
        bytes_remaining_next   = remaining_dec;
        push                   = 1'b1;
        push_beat.payload_byte = rx_byte;
        push_beat.frame_end    = (remaining_dec == '0);
        in_payload_next        = (remaining_dec != '0);
      end else if (rx_byte[7]) begin
        if (seen_inc >= CNT_W'(MAX_PREFIX_BYTES)) begin
          // prefix ran too long: drop it and resync
          push                   = 1'b1;
          push_beat.status       = STATUS_LONG_PREFIX;
          prefix_value_next      = '0;
          prefix_bytes_seen_next = '0;
        end else begin
          prefix_value_next      = merged;
          prefix_bytes_seen_next = seen_inc;
        end
      end else begin
        prefix_value_next      = '0;
        prefix_bytes_seen_next = '0;
        if (merged == '0 || merged[LENGTH_W-1]) begin
          push             = 1'b1;
          push_beat.status = STATUS_BAD_LENGTH;
        end else begin
          bytes_remaining_next = merged[LENGTH_W-2:0];
          in_payload_next      = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_payload        <= 1'b0;
      prefix_value      <= '0;
      prefix_bytes_seen <= '0;
      bytes_remaining   <= '0;
    end else begin
      in_payload        <= in_payload_next;
      prefix_value      <= prefix_value_next;
      prefix_bytes_seen <= prefix_bytes_seen_next;
      bytes_remaining   <= bytes_remaining_next;
    end
  end

  a_err_only_in_prefix: assert property (@(posedge clk) disable iff (rst)
    push && push_beat.status != STATUS_OK |-> !in_payload)
    else $error("error beat while passing payload");

  a_err_resyncs: assert property (@(posedge clk) disable iff (rst)
    push && push_beat.status != STATUS_OK |=> !in_payload && prefix_bytes_seen == '0)
    else $error("no resync after error beat");

  a_payload_has_count: assert property (@(posedge clk) disable iff (rst)
    in_payload |-> bytes_remaining != '0)
    else $error("payload mode with no bytes left");

endmodule
`default_nettype wire

FILE: sv/vlpd_queue.sv
`default_nettype none
module vlpd_queue (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            push,
  input  wire vlpd_pkg::beat_t push_beat,
  output logic                 full,
  output logic                 out_valid,
  input  wire logic            out_ready,
  output vlpd_pkg::beat_t      out_beat
);
  import vlpd_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  beat_t            entries [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             pop;

  assign full      = (count == CNT_W'(QUEUE_DEPTH));
  assign out_valid = (count != '0);
  assign pop       = out_valid && out_ready;
  assign out_beat  = entries[rd_ptr];

  function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_beat;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= bump(wr_ptr);
      if (pop)  rd_ptr <= bump(rd_ptr);
      if (push && !pop) count <= count + CNT_W'(1);
      else if (pop && !push) count <= count - CNT_W'(1);
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> !full)
    else $error("push into full queue");

  a_count_tracks: assert property (@(posedge clk) disable iff (rst)
    push && !pop |=> count == $past(count) + CNT_W'(1))
    else $error("queue count lost a beat");

endmodule
`default_nettype wire

FILE: sv/varint_length_prefix_deframer.sv
`default_nettype none
// Output: a payload or error beat is written into the queue when its byte is taken
// and shows on the outputs from the queue; length prefix bytes that end well give no beat.
// Throughput: one byte per cycle while out_ready keeps up; the two-entry queue
// between the prefix decoder and the output side absorbs a stall of the sink.
// Reset (rst, synchronous): back to reading a prefix, queue emptied.
module varint_length_prefix_deframer #(
  parameter int MAX_PREFIX_BYTES = vlpd_pkg::MAX_PREFIX_BYTES_DEFAULT
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       rx_valid,
  output logic            rx_ready,
  input  wire logic [7:0] rx_byte,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [7:0]      payload_byte,
  output logic            frame_end,
  output logic [1:0]      status
);
  import vlpd_pkg::*;

  logic  push;
  logic  queue_full;
  beat_t push_beat;
  beat_t out_beat;

  vlpd_front #(
    .MAX_PREFIX_BYTES(MAX_PREFIX_BYTES)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .rx_valid  (rx_valid),
    .rx_ready  (rx_ready),
    .rx_byte   (rx_byte),
    .queue_full(queue_full),
    .push      (push),
    .push_beat (push_beat)
  );

  vlpd_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_beat(push_beat),
    .full     (queue_full),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_beat (out_beat)
  );

  assign payload_byte = out_beat.payload_byte;
  assign frame_end    = out_beat.frame_end;
  assign status       = out_beat.status;

endmodule
`default_nettype wire

FILE: tb/sv/tb_varint_length_prefix_deframer.sv
`timescale 1ns / 100ps

module tb_varint_length_prefix_deframer;
  import vlpd_pkg::*;

  localparam int MAX_PFX = MAX_PREFIX_BYTES_DEFAULT;
  localparam int RANDOM_ITEMS = 1950;

  typedef struct {
    logic [7:0]  data;
    int unsigned gap;
    bit          drain;
  } rx_item_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       rx_valid = 1'b0;
  logic       rx_ready;
  logic [7:0] rx_byte = 8'd0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [7:0] payload_byte;
  logic       frame_end;
  logic [1:0] status;

  varint_length_prefix_deframer dut (
    .clk          (clk),
    .rst          (rst),
    .rx_valid     (rx_valid),
    .rx_ready     (rx_ready),
    .rx_byte      (rx_byte),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .payload_byte (payload_byte),
    .frame_end    (frame_end),
    .status       (status)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  rx_item_t    rx_pending[$];
  beat_t       expected_beats[$];
  int unsigned beats_predicted = 0;
  int unsigned beats_received = 0;
  int unsigned err_count = 0;
  bit          src_fast = 1'b0;

  // deframer state as the byte stream should leave it
  bit          in_frame = 1'b0;
  logic [31:0] pfx_value = '0;
  int unsigned pfx_count = 0;
  logic [30:0] left_in_frame = '0;

  task automatic report_mismatch(input string what);
    $display("MISMATCH @%0t: %s", $realtime, what);
    err_count++;
  endtask

  function automatic void push_beat(logic [7:0] data, logic last, status_t st);
    beat_t bt;
    bt.payload_byte = data;
    bt.frame_end = last;
    bt.status = st;
    expected_beats.push_back(bt);
    beats_predicted++;
  endfunction

  function automatic void decode_rx_byte(logic [7:0] b);
    int unsigned shift;
    if (in_frame) begin
      left_in_frame = left_in_frame - 31'd1;
      if (left_in_frame == 31'd0) begin
        in_frame = 1'b0;
        push_beat(b, 1'b1, STATUS_OK);
      end else begin
        push_beat(b, 1'b0, STATUS_OK);
      end
    end else begin
      shift = GROUP_BITS * pfx_count;
      // groups past bit 31 fall off the top
      if (shift < LENGTH_W) pfx_value = pfx_value | ({25'd0, b[6:0]} << shift);
      pfx_count++;
      if (b[7]) begin
        if (pfx_count >= MAX_PFX) begin
          pfx_value = '0;
          pfx_count = 0;
          push_beat(8'd0, 1'b0, STATUS_LONG_PREFIX);
        end
      end else if (pfx_value == 32'd0 || pfx_value[31]) begin
        pfx_value = '0;
        pfx_count = 0;
        push_beat(8'd0, 1'b0, STATUS_BAD_LENGTH);
      end else begin
        left_in_frame = pfx_value[30:0];
        pfx_value = '0;
        pfx_count = 0;
        in_frame = 1'b1;
      end
    end
  endfunction

  // driver: present queued bytes, each after its own idle gap
  int unsigned src_gap_cnt = 0;
  always @(posedge clk) begin
    bit nxt_valid;
    if (rst) begin
      rx_valid <= 1'b0;
      src_gap_cnt = 0;
    end else begin
      nxt_valid = rx_valid;
      if (rx_valid && rx_ready) begin
        decode_rx_byte(rx_byte);
        nxt_valid = 1'b0;
      end
      if (!nxt_valid && rx_pending.size() != 0) begin
        if (rx_pending[0].drain && beats_predicted != beats_received) begin
          // hold until every expected beat is out
        end else if (src_gap_cnt < rx_pending[0].gap) begin
          src_gap_cnt++;
        end else begin
          rx_byte <= rx_pending[0].data;
          nxt_valid = 1'b1;
          src_gap_cnt = 0;
          void'(rx_pending.pop_front());
        end
      end
      rx_valid <= nxt_valid;
    end
  end

  // monitor: take beats, check against the oldest expectation
  int unsigned sink_wait = 0;
  int unsigned sink_hold = 0;
  int unsigned sink_seen = 0;
  bit          sink_fast = 1'b0;
  always @(posedge clk) begin
    beat_t want;
    bit    nxt_ready;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        sink_seen++;
        beats_received <= beats_received + 1;
        if (expected_beats.size() == 0) begin
          report_mismatch($sformatf("unexpected beat byte=%02h end=%0d status=%0d",
                                    payload_byte, frame_end, status));
        end else begin
          want = expected_beats.pop_front();
          if (payload_byte !== want.payload_byte)
            report_mismatch($sformatf("beat %0d payload_byte %02h, want %02h",
                                      sink_seen, payload_byte, want.payload_byte));
          if (frame_end !== want.frame_end)
            report_mismatch($sformatf("beat %0d frame_end %0d, want %0d",
                                      sink_seen, frame_end, want.frame_end));
          if (status !== want.status)
            report_mismatch($sformatf("beat %0d status %0d, want %0d",
                                      sink_seen, status, want.status));
        end
        sink_wait = sink_fast ? 0 : $urandom_range(0, 17);
        if (sink_seen % 150 == 0) sink_fast = !sink_fast;
        // long back-pressure so the input side fills and stalls
        if (sink_seen == 300 || sink_seen == 1100) sink_hold = 90;
      end
      if (sink_hold != 0) begin
        sink_hold--;
        nxt_ready = 1'b0;
      end else if (sink_wait != 0) begin
        sink_wait--;
        nxt_ready = 1'b0;
      end else begin
        nxt_ready = 1'b1;
      end
      out_ready <= nxt_ready;
    end
  end

  task automatic add_byte(input logic [7:0] d, input bit drain = 1'b0);
    rx_item_t it;
    it.data = d;
    it.gap = src_fast ? 0 : $urandom_range(0, 17);
    it.drain = drain;
    rx_pending.push_back(it);
  endtask

  // varint of len over nbytes groups; a fifth group carries junk above bit 31
  task automatic add_length(input int unsigned len, input int unsigned nbytes);
    logic [7:0] b;
    for (int i = 0; i < nbytes; i++) begin
      b = {1'b0, 7'((len >> (7 * i)) & 32'h7f)};
      if (i == 4) b[6:4] = 3'($urandom_range(0, 7));
      if (i != nbytes - 1) b[7] = 1'b1;
      add_byte(b);
    end
  endtask

  task automatic add_random_frame();
    int unsigned r, len, min_w, w;
    r = $urandom_range(0, 99);
    if (r < 80) begin
      r = $urandom_range(0, 99);
      if (r < 70) len = $urandom_range(1, 8);
      else if (r < 95) len = $urandom_range(9, 40);
      else len = $urandom_range(100, 300);
      min_w = (len < 128) ? 1 : 2;
      w = ($urandom_range(0, 99) < 85) ? min_w : $urandom_range(min_w, MAX_PFX);
      add_length(len, w);
      for (int i = 0; i < len; i++) add_byte(8'($urandom_range(0, 255)));
    end else if (r < 87) begin
      add_length(0, $urandom_range(1, MAX_PFX));
    end else if (r < 93) begin
      for (int i = 0; i < MAX_PFX - 1; i++) add_byte(8'($urandom_range(0, 127)) | 8'h80);
      add_byte(8'($urandom_range(0, 127)) | 8'h08);
    end else begin
      for (int i = 0; i < MAX_PFX; i++) add_byte(8'($urandom_range(0, 127)) | 8'h80);
    end
  endtask

  initial begin
    // zero length, short frame with extreme payload, padded prefix
    add_byte(8'h00);
    add_byte(8'h02); add_byte(8'h00); add_byte(8'hff);
    add_byte(8'h81); add_byte(8'h00); add_byte(8'h5a);
    // prefix too long
    repeat (5) add_byte(8'hff);
    // all ones: negative length
    repeat (4) add_byte(8'hff);
    add_byte(8'h0f);
    // length 3 with junk above bit 31 dropped
    add_byte(8'h83); add_byte(8'h80); add_byte(8'h80); add_byte(8'h80); add_byte(8'h70);
    add_byte(8'h01); add_byte(8'h80); add_byte(8'h7f);

    // first random byte waits for the directed part to drain
    add_byte(8'h01, 1'b1);
    add_byte(8'($urandom_range(0, 255)));
    while (rx_pending.size() < RANDOM_ITEMS) begin
      if ($urandom_range(0, 7) == 0) src_fast = !src_fast;
      if (rx_pending.size() > RANDOM_ITEMS / 2 && rx_pending.size() < RANDOM_ITEMS / 2 + 40
          && !rx_pending[rx_pending.size() - 1].drain) begin
        add_byte(8'h00, 1'b1);
      end
      add_random_frame();
    end

    repeat (6) @(posedge clk);
    rst <= 1'b0;
    // sample between edges so the driver's and monitor's updates have settled
    while (rx_pending.size() != 0 || rx_valid) @(negedge clk);
    while (expected_beats.size() != 0) @(negedge clk);
    repeat (20) @(posedge clk);
    if (err_count == 0) begin
      $display("tb_varint_length_prefix_deframer: done, clean");
    end else begin
      $display("tb_varint_length_prefix_deframer: done, errors");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("TIMEOUT: %0d beats still expected", expected_beats.size());
    $display("tb_varint_length_prefix_deframer: done, errors");
    $finish;
  end

endmodule

FILE: varint_length_prefix_deframer.f
sv/vlpd_pkg.sv
sv/vlpd_front.sv
sv/vlpd_queue.sv
sv/varint_length_prefix_deframer.sv
tb/sv/tb_varint_length_prefix_deframer.sv
